// ----- rtl/priority_round_robin_scheduler_assert.svh -----
// Assertion macros for the priority round-robin scheduler.
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_ASSERT_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_ASSERT_SVH
`ifndef ASSERT_OFF
`define PRRS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PRRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PRRS_ASSERT_IMPLY(lbl, ante, cons, msg)
`define PRRS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/prrs_pkg.sv -----
// Shared constants, types and the ordering function of the scheduler.
`default_nettype none
package prrs_pkg;
  localparam int MAX_PROCS  = 8;
  localparam int TABLE_CAP  = 6;
  localparam int PROC_LIMIT = (MAX_PROCS < TABLE_CAP) ? MAX_PROCS : TABLE_CAP;
  localparam int SLOT_W     = $clog2(MAX_PROCS);
  localparam int LEN_W      = $clog2(MAX_PROCS + 1);

  // Command kinds.
  localparam logic [2:0] K_ADD     = 3'd0;
  localparam logic [2:0] K_TICK    = 3'd1;
  localparam logic [2:0] K_PREEMPT = 3'd2;
  localparam logic [2:0] K_BLOCK   = 3'd3;
  localparam logic [2:0] K_WAKE    = 3'd4;
  localparam logic [2:0] K_SUSPEND = 3'd5;
  localparam logic [2:0] K_RESUME  = 3'd6;
  localparam logic [2:0] K_CLEAR   = 3'd7;

  // Status codes.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  // Process states.
  localparam logic [1:0] ST_READY = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_SUSP  = 2'd3;

  // Register indexes.
  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_SLICE = 1'b1;

  // Cell operations.
  localparam logic [1:0] OP_HOLD  = 2'd0;
  localparam logic [1:0] OP_SHIFT = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;
  localparam logic [1:0] OP_SORT  = 2'd3;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [7:0]        prio;
    logic [7:0]        ident;
  } cell_t;

  typedef struct packed {
    logic [1:0]       op;
    logic             parity;
    logic [LEN_W-1:0] len;
    cell_t            new_cell;
  } cell_ctrl_t;

  function automatic logic key_after(input cell_t a, input cell_t b);
    logic r;
    if (a.prio != b.prio) begin
      r = a.prio > b.prio;
    end else begin
      r = a.ident > b.ident;
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/priority_round_robin_scheduler.sv -----
// Top level of the priority and round-robin process scheduler.
`default_nettype none
`include "priority_round_robin_scheduler_assert.svh"
// The scheduler keeps a table of eight slots, of which at most six hold
// processes, and a ready order kept in a chain of cells, one entry per cell.
// Each request carries one command (add, tick, preempt, block, wake, suspend,
// resume or clear) and yields exactly one response. A request is accepted,
// then executed against the table and the chain, and then its response is
// registered. A command that puts a process into the ready order while in
// priority mode adds a sort state before the response, in which the chain
// runs one odd-even transposition pass per cycle. A new request is accepted
// while an earlier response still waits on the output. Configuration writes
// are always accepted and take effect at once; they are meant to arrive only
// while no request is in flight. There is no clearing pass after reset.
module priority_round_robin_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_kind,
  input  wire logic [7:0]  in_target_id,
  input  wire logic [15:0] in_burst_time,
  input  wire logic [7:0]  in_prio_level,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status_code,
  output logic [7:0]       out_assigned_id,
  output logic             out_run_valid,
  output logic [7:0]       out_run_id,
  output logic [15:0]      out_run_remaining,
  output logic             out_retired_valid,
  output logic             out_rotated_valid,
  output logic [3:0]       out_ready_count,
  output logic [3:0]       out_proc_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata
);
  localparam int NP = prrs_pkg::MAX_PROCS;
  localparam int SW = prrs_pkg::SLOT_W;
  localparam int LW = prrs_pkg::LEN_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SORT = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]    fsm_r, fsm_nxt;
  logic          mode_r;
  logic [7:0]    slice_len_r;

  // Latched request.
  logic [2:0]    kind_r;
  logic [7:0]    target_r;
  logic [15:0]   burst_r;
  logic [7:0]    prio_r;

  // Process table.
  logic [NP-1:0] ent_valid_r;
  logic [7:0]    ent_ident_r [NP];
  logic [15:0]   ent_rem_r   [NP];
  logic [7:0]    ent_prio_r  [NP];
  logic [1:0]    ent_state_r [NP];

  logic [LW-1:0] len_r, len_nxt;
  logic          busy_r, busy_nxt;
  logic [SW-1:0] cpu_r, cpu_nxt;
  logic [7:0]    slice_r, slice_nxt;
  logic [7:0]    next_id_r, next_id_nxt;
  logic [SW-1:0] sort_cnt_r;

  // Results of the execute step, held until the response is registered.
  logic [1:0]    stat_r, ex_status;
  logic [7:0]    asg_r, ex_assigned;
  logic          ret_r, ex_retired;
  logic          rot_r, ex_rotated;

  // Execute-step decisions.
  logic          ex_append, ex_drop, ex_sort, ex_clear;
  logic [SW-1:0] ex_app_slot, ex_drop_slot;
  logic          ex_new_we, ex_dec_we, ex_inval;
  logic          ex_st_we;
  logic [SW-1:0] ex_st_slot;
  logic [1:0]    ex_st_val;

  // Table lookups.
  logic          hit;
  logic [SW-1:0] hit_idx;
  logic [SW-1:0] free_idx;
  logic [LW-1:0] proc_cnt;
  logic [7:0]    slice_inc;

  // Chain.
  prrs_pkg::cell_t      cells [NP];
  prrs_pkg::cell_ctrl_t cctrl;
  logic [NP-1:0]        drop_match, shift_mask;

  logic out_valid_r;
  logic do_exec, do_resp;

  assign in_ready  = (fsm_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign do_exec   = (fsm_r == S_EXEC);
  assign do_resp   = (fsm_r == S_RESP) && (!out_valid_r || out_ready);

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    proc_cnt = '0;
    for (int i = NP - 1; i >= 0; i--) begin
      if (ent_valid_r[i] && (ent_ident_r[i] == target_r)) begin
        hit     = 1'b1;
        hit_idx = SW'(i);
      end
      if (!ent_valid_r[i]) begin
        free_idx = SW'(i);
      end
    end
    for (int i = 0; i < NP; i++) begin
      proc_cnt = proc_cnt + LW'(ent_valid_r[i]);
    end
  end

  assign slice_inc = (slice_r != 8'hFF) ? (slice_r + 8'd1) : slice_r;

  always_comb begin
    ex_status    = prrs_pkg::STAT_OK;
    ex_assigned  = '0;
    ex_retired   = 1'b0;
    ex_rotated   = 1'b0;
    ex_append    = 1'b0;
    ex_app_slot  = cpu_r;
    ex_drop      = 1'b0;
    ex_drop_slot = hit_idx;
    ex_sort      = 1'b0;
    ex_clear     = 1'b0;
    ex_new_we    = 1'b0;
    ex_dec_we    = 1'b0;
    ex_inval     = 1'b0;
    ex_st_we     = 1'b0;
    ex_st_slot   = cpu_r;
    ex_st_val    = prrs_pkg::ST_READY;
    busy_nxt     = busy_r;
    cpu_nxt      = cpu_r;
    slice_nxt    = slice_r;
    next_id_nxt  = next_id_r;
    case (kind_r)
      prrs_pkg::K_ADD: begin
        if (proc_cnt >= LW'(prrs_pkg::PROC_LIMIT)) begin
          ex_status = prrs_pkg::STAT_FULL;
        end else begin
          ex_new_we   = 1'b1;
          ex_assigned = next_id_r;
          next_id_nxt = next_id_r + 8'd1;
          ex_append   = 1'b1;
          ex_app_slot = free_idx;
          ex_st_we    = 1'b1;
          ex_st_slot  = free_idx;
          ex_sort     = !mode_r;
        end
      end
      prrs_pkg::K_TICK: begin
        if (!busy_r) begin
          if (len_r != '0) begin
            cpu_nxt      = cells[0].slot;
            ex_drop      = 1'b1;
            ex_drop_slot = cells[0].slot;
            ex_st_we     = 1'b1;
            ex_st_slot   = cells[0].slot;
            ex_st_val    = prrs_pkg::ST_RUN;
            busy_nxt     = 1'b1;
            slice_nxt    = '0;
          end
        end else if (ent_rem_r[cpu_r] == '0) begin
          ex_inval   = 1'b1;
          busy_nxt   = 1'b0;
          ex_retired = 1'b1;
        end else begin
          ex_dec_we = 1'b1;
          if (mode_r) begin
            slice_nxt = slice_inc;
            if (slice_inc >= slice_len_r) begin
              busy_nxt   = 1'b0;
              ex_append  = 1'b1;
              ex_st_we   = 1'b1;
              ex_rotated = 1'b1;
            end
          end
        end
      end
      prrs_pkg::K_PREEMPT, prrs_pkg::K_BLOCK: begin
        if (!busy_r) begin
          ex_status = prrs_pkg::STAT_BAD;
        end else begin
          busy_nxt = 1'b0;
          ex_st_we = 1'b1;
          if (kind_r == prrs_pkg::K_PREEMPT) begin
            ex_append = 1'b1;
            ex_sort   = !mode_r;
          end else begin
            ex_st_val = prrs_pkg::ST_WAIT;
          end
        end
      end
      prrs_pkg::K_WAKE, prrs_pkg::K_RESUME: begin
        if (!hit || (ent_state_r[hit_idx] != ((kind_r == prrs_pkg::K_WAKE) ?
                                               prrs_pkg::ST_WAIT : prrs_pkg::ST_SUSP))) begin
          ex_status = prrs_pkg::STAT_BAD;
        end else begin
          ex_append   = 1'b1;
          ex_app_slot = hit_idx;
          ex_st_we    = 1'b1;
          ex_st_slot  = hit_idx;
          ex_sort     = !mode_r;
        end
      end
      prrs_pkg::K_SUSPEND: begin
        if (!hit || (ent_state_r[hit_idx] == prrs_pkg::ST_SUSP)) begin
          ex_status = prrs_pkg::STAT_BAD;
        end else begin
          if (ent_state_r[hit_idx] == prrs_pkg::ST_RUN) begin
            busy_nxt = 1'b0;
          end else if (ent_state_r[hit_idx] == prrs_pkg::ST_READY) begin
            ex_drop = 1'b1;
          end
          ex_st_we   = 1'b1;
          ex_st_slot = hit_idx;
          ex_st_val  = prrs_pkg::ST_SUSP;
        end
      end
      default: begin
        ex_clear    = 1'b1;
        busy_nxt    = 1'b0;
        cpu_nxt     = '0;
        slice_nxt   = '0;
        next_id_nxt = '0;
      end
    endcase
  end

  // Removal compacts the chain: every cell at or after the match takes its
  // right neighbor.
  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int i = 0; i < NP; i++) begin
      drop_match[i] = (cells[i].slot == ex_drop_slot) && (LW'(i) < len_r);
      acc           = acc | drop_match[i];
      shift_mask[i] = acc;
    end
  end

  always_comb begin
    cctrl.op                = prrs_pkg::OP_HOLD;
    cctrl.parity            = sort_cnt_r[0];
    cctrl.len               = len_r;
    cctrl.new_cell.slot     = ex_app_slot;
    cctrl.new_cell.prio     = (kind_r == prrs_pkg::K_ADD) ? prio_r : ent_prio_r[ex_app_slot];
    cctrl.new_cell.ident    = (kind_r == prrs_pkg::K_ADD) ? next_id_r : ent_ident_r[ex_app_slot];
    if (do_exec && ex_append && (len_r < LW'(NP))) begin
      cctrl.op = prrs_pkg::OP_LOAD;
    end else if (do_exec && ex_drop) begin
      cctrl.op = prrs_pkg::OP_SHIFT;
    end else if (fsm_r == S_SORT) begin
      cctrl.op = prrs_pkg::OP_SORT;
    end
  end

  for (genvar g = 0; g < NP; g++) begin : g_cell
    prrs_cell u_cell (
      .clk      (clk),
      .self_idx (SW'(g)),
      .ctrl     (cctrl),
      .shift_en (shift_mask[g]),
      .left_i   (cells[(g == 0) ? 0 : g - 1]),
      .right_i  (cells[(g == NP - 1) ? g : g + 1]),
      .cell_o   (cells[g])
    );
  end

  always_comb begin
    len_nxt = len_r;
    if (ex_clear) begin
      len_nxt = '0;
    end else if (ex_append) begin
      if (len_r < LW'(NP)) begin
        len_nxt = len_r + 1'b1;
      end
    end else if (ex_drop && (drop_match != '0)) begin
      len_nxt = len_r - 1'b1;
    end
  end

  always_comb begin
    fsm_nxt = fsm_r;
    unique case (fsm_r)
      S_IDLE: begin
        if (in_valid) begin
          fsm_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        fsm_nxt = (ex_append && ex_sort) ? S_SORT : S_RESP;
      end
      S_SORT: begin
        if (sort_cnt_r == SW'(NP - 1)) begin
          fsm_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (do_resp) begin
          fsm_nxt = S_IDLE;
        end
      end
      default: begin
        fsm_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= S_IDLE;
      mode_r      <= 1'b0;
      slice_len_r <= 8'd5;
      ent_valid_r <= '0;
      len_r       <= '0;
      busy_r      <= 1'b0;
      cpu_r       <= '0;
      slice_r     <= '0;
      next_id_r   <= '0;
      sort_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r <= fsm_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == prrs_pkg::CFG_MODE) begin
          mode_r <= cfg_wdata[0];
        end else begin
          slice_len_r <= cfg_wdata;
        end
      end
      if (do_exec) begin
        len_r     <= len_nxt;
        busy_r    <= busy_nxt;
        cpu_r     <= cpu_nxt;
        slice_r   <= slice_nxt;
        next_id_r <= next_id_nxt;
        if (ex_clear) begin
          ent_valid_r <= '0;
        end else if (ex_new_we) begin
          ent_valid_r[free_idx] <= 1'b1;
        end else if (ex_inval) begin
          ent_valid_r[cpu_r] <= 1'b0;
        end
      end
      sort_cnt_r <= (fsm_r == S_SORT) ? (sort_cnt_r + 1'b1) : '0;
      if (do_resp) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r   <= in_kind;
      target_r <= in_target_id;
      burst_r  <= in_burst_time;
      prio_r   <= in_prio_level;
    end
    if (do_exec) begin
      stat_r <= ex_status;
      asg_r  <= ex_assigned;
      ret_r  <= ex_retired;
      rot_r  <= ex_rotated;
      if (ex_new_we) begin
        ent_ident_r[free_idx] <= next_id_r;
        ent_rem_r[free_idx]   <= burst_r;
        ent_prio_r[free_idx]  <= prio_r;
      end
      if (ex_dec_we) begin
        ent_rem_r[cpu_r] <= ent_rem_r[cpu_r] - 16'd1;
      end
      if (ex_st_we) begin
        ent_state_r[ex_st_slot] <= ex_st_val;
      end
    end
    if (do_resp) begin
      out_status_code   <= stat_r;
      out_assigned_id   <= asg_r;
      out_run_valid     <= busy_r;
      out_run_id        <= busy_r ? ent_ident_r[cpu_r] : 8'd0;
      out_run_remaining <= busy_r ? ent_rem_r[cpu_r] : 16'd0;
      out_retired_valid <= ret_r;
      out_rotated_valid <= rot_r;
      out_ready_count   <= 4'(len_r);
      out_proc_count    <= 4'(proc_cnt);
    end
  end

  assign out_valid = out_valid_r;

  // The ready order never holds more processes than the table may.
  `PRRS_ASSERT_IMPLY(a_len_bound, 1'b1, len_r <= LW'(prrs_pkg::PROC_LIMIT), "ready order too long")
  // A running process always occupies a valid slot.
  `PRRS_ASSERT_IMPLY(a_busy_valid, busy_r, ent_valid_r[cpu_r], "running slot not valid")
  // The head of the ready order refers to a valid slot.
  `PRRS_ASSERT_IMPLY(a_head_valid, len_r != '0, ent_valid_r[cells[0].slot], "ready head not valid")
  // One request at a time: an accepted request blocks the next cycle.
  `PRRS_ASSERT_NEXT(a_one_req, in_valid && in_ready, !in_ready, "request overlap")
endmodule
`default_nettype wire

// ----- rtl/prrs_cell.sv -----
// One cell of the ready-order chain: holds one entry and trades with its neighbors.
`default_nettype none
module prrs_cell (
  input  wire logic                        clk,
  input  wire logic [prrs_pkg::SLOT_W-1:0] self_idx,
  input  wire prrs_pkg::cell_ctrl_t        ctrl,
  input  wire logic                        shift_en,
  input  wire prrs_pkg::cell_t             left_i,
  input  wire prrs_pkg::cell_t             right_i,
  output prrs_pkg::cell_t                  cell_o
);
  prrs_pkg::cell_t             cell_r;
  prrs_pkg::cell_t             cell_nxt;
  logic [prrs_pkg::LEN_W-1:0]  idx_ext;
  logic                        is_left;

  assign idx_ext = prrs_pkg::LEN_W'(self_idx);
  assign is_left = (self_idx[0] == ctrl.parity);

  always_comb begin
    cell_nxt = cell_r;
    case (ctrl.op)
      prrs_pkg::OP_SHIFT: begin
        if (shift_en) begin
          cell_nxt = right_i;
        end
      end
      prrs_pkg::OP_LOAD: begin
        if (idx_ext == ctrl.len) begin
          cell_nxt = ctrl.new_cell;
        end
      end
      prrs_pkg::OP_SORT: begin
        // Odd-even transposition: swap a pair only when strictly out of order.
        if (is_left) begin
          if ((idx_ext + 1'b1 < ctrl.len) && prrs_pkg::key_after(cell_r, right_i)) begin
            cell_nxt = right_i;
          end
        end else if ((self_idx != '0) && (idx_ext < ctrl.len) &&
                     prrs_pkg::key_after(left_i, cell_r)) begin
          cell_nxt = left_i;
        end
      end
      default: begin
        cell_nxt = cell_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cell_o = cell_r;
endmodule
`default_nettype wire

// ----- bench/priority_round_robin_scheduler_tb.sv -----
// Self-checking testbench for the priority and round-robin process scheduler.
`timescale 1ns / 1ps
`default_nettype none
module priority_round_robin_scheduler_tb;

  // One response of the scheduler, field by field.
  typedef struct {
    logic [1:0]  status_code;
    logic [7:0]  assigned_id;
    logic        run_valid;
    logic [7:0]  run_id;
    logic [15:0] run_remaining;
    logic        retired_valid;
    logic        rotated_valid;
    logic [3:0]  ready_count;
    logic [3:0]  proc_count;
  } sched_resp_t;

  // Scheduler predictor: mirrors the process table, the ready order and the CPU.
  class sched_scoreboard;
    logic             mode;
    logic [7:0]       slice;
    logic             valid_q[prrs_pkg::MAX_PROCS];
    logic [7:0]       ident_q[prrs_pkg::MAX_PROCS];
    logic [15:0]      remain_q[prrs_pkg::MAX_PROCS];
    logic [7:0]       prio_q[prrs_pkg::MAX_PROCS];
    logic [1:0]       state_q[prrs_pkg::MAX_PROCS];
    int               ready_q[$];
    logic             busy;
    int               slot;
    logic [7:0]       ticks;
    logic [7:0]       next_id;
    sched_resp_t      pending[$];
    int               errors;

    function void clear_table();
      for (int i = 0; i < prrs_pkg::MAX_PROCS; i++) begin
        valid_q[i] = 0; ident_q[i] = 0; remain_q[i] = 0; prio_q[i] = 0;
        state_q[i] = prrs_pkg::ST_READY;
      end
      ready_q.delete();
      busy = 0; slot = 0; ticks = 0; next_id = 0;
    endfunction

    function void reset_state();
      mode = 0;
      slice = 8'd5;
      errors = 0;
      clear_table();
    endfunction

    function void write_reg(logic idx, logic [7:0] data);
      if (idx == prrs_pkg::CFG_MODE) mode = data[0];
      else slice = data;
    endfunction

    // Priority order is a stable sort by priority, then id.
    function bit later_than(int a, int b);
      if (prio_q[a] != prio_q[b]) return prio_q[a] > prio_q[b];
      return ident_q[a] > ident_q[b];
    endfunction

    function void enqueue_ready(int s);
      int j;
      int v;
      state_q[s] = prrs_pkg::ST_READY;
      ready_q.push_back(s);
      if (mode == 1'b0) begin
        for (int i = 1; i < ready_q.size(); i++) begin
          v = ready_q[i];
          j = i;
          while (j > 0 && later_than(ready_q[j-1], v)) begin
            ready_q[j] = ready_q[j-1];
            j--;
          end
          ready_q[j] = v;
        end
      end
    endfunction

    function void remove_ready(int s);
      for (int i = ready_q.size() - 1; i >= 0; i--)
        if (ready_q[i] == s) ready_q.delete(i);
    endfunction

    function int lookup(logic [7:0] id);
      for (int i = 0; i < prrs_pkg::MAX_PROCS; i++)
        if (valid_q[i] && ident_q[i] == id) return i;
      return -1;
    endfunction

    function int live_count();
      int n;
      n = 0;
      for (int i = 0; i < prrs_pkg::MAX_PROCS; i++) n += valid_q[i];
      return n;
    endfunction

    // Applies one accepted request and queues the response it must produce.
    function void note_request(logic [2:0] kind, logic [7:0] tgt, logic [15:0] burst,
                               logic [7:0] prio);
      sched_resp_t r;
      int t;
      int f;
      r = '{default: '0};
      case (kind)
        prrs_pkg::K_ADD: begin
          f = -1;
          for (int i = prrs_pkg::MAX_PROCS - 1; i >= 0; i--) if (!valid_q[i]) f = i;
          if (live_count() >= prrs_pkg::PROC_LIMIT || f < 0) begin
            r.status_code = prrs_pkg::STAT_FULL;
          end else begin
            valid_q[f] = 1; ident_q[f] = next_id; remain_q[f] = burst; prio_q[f] = prio;
            r.assigned_id = next_id;
            next_id++;
            enqueue_ready(f);
          end
        end
        prrs_pkg::K_TICK: begin
          if (!busy) begin
            if (ready_q.size() > 0) begin
              slot = ready_q[0];
              remove_ready(slot);
              state_q[slot] = prrs_pkg::ST_RUN;
              busy = 1;
              ticks = 0;
            end
          end else if (remain_q[slot] == 0) begin
            valid_q[slot] = 0;
            busy = 0;
            r.retired_valid = 1;
          end else begin
            remain_q[slot]--;
            if (mode) begin
              if (ticks != 8'hff) ticks++;
              if (ticks >= slice) begin
                busy = 0;
                enqueue_ready(slot);
                r.rotated_valid = 1;
              end
            end
          end
        end
        prrs_pkg::K_PREEMPT, prrs_pkg::K_BLOCK: begin
          if (!busy) begin
            r.status_code = prrs_pkg::STAT_BAD;
          end else begin
            busy = 0;
            if (kind == prrs_pkg::K_PREEMPT) enqueue_ready(slot);
            else state_q[slot] = prrs_pkg::ST_WAIT;
          end
        end
        prrs_pkg::K_WAKE, prrs_pkg::K_RESUME: begin
          t = lookup(tgt);
          if (t < 0 || state_q[t] != ((kind == prrs_pkg::K_WAKE) ?
                                      prrs_pkg::ST_WAIT : prrs_pkg::ST_SUSP))
            r.status_code = prrs_pkg::STAT_BAD;
          else enqueue_ready(t);
        end
        prrs_pkg::K_SUSPEND: begin
          t = lookup(tgt);
          if (t < 0 || state_q[t] == prrs_pkg::ST_SUSP) begin
            r.status_code = prrs_pkg::STAT_BAD;
          end else begin
            if (state_q[t] == prrs_pkg::ST_RUN) busy = 0;
            else if (state_q[t] == prrs_pkg::ST_READY) remove_ready(t);
            state_q[t] = prrs_pkg::ST_SUSP;
          end
        end
        default: clear_table();
      endcase
      r.run_valid = busy;
      r.run_id = busy ? ident_q[slot] : 8'd0;
      r.run_remaining = busy ? remain_q[slot] : 16'd0;
      r.ready_count = 4'(ready_q.size());
      r.proc_count = 4'(live_count());
      pending.push_back(r);
    endfunction

    function void check_response(sched_resp_t got);
      sched_resp_t e;
      if (pending.size() == 0) begin
        $error("unexpected response with nothing pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status_code !== e.status_code) begin
        $error("status_code exp %0d got %0d", e.status_code, got.status_code); errors++;
      end
      if (got.assigned_id !== e.assigned_id) begin
        $error("assigned_id exp %0d got %0d", e.assigned_id, got.assigned_id); errors++;
      end
      if (got.run_valid !== e.run_valid) begin
        $error("run_valid exp %0d got %0d", e.run_valid, got.run_valid); errors++;
      end
      if (got.run_id !== e.run_id) begin
        $error("run_id exp %0d got %0d", e.run_id, got.run_id); errors++;
      end
      if (got.run_remaining !== e.run_remaining) begin
        $error("run_remaining exp %0d got %0d", e.run_remaining, got.run_remaining); errors++;
      end
      if (got.retired_valid !== e.retired_valid) begin
        $error("retired_valid exp %0d got %0d", e.retired_valid, got.retired_valid); errors++;
      end
      if (got.rotated_valid !== e.rotated_valid) begin
        $error("rotated_valid exp %0d got %0d", e.rotated_valid, got.rotated_valid); errors++;
      end
      if (got.ready_count !== e.ready_count) begin
        $error("ready_count exp %0d got %0d", e.ready_count, got.ready_count); errors++;
      end
      if (got.proc_count !== e.proc_count) begin
        $error("proc_count exp %0d got %0d", e.proc_count, got.proc_count); errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 1500000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  in_kind = prrs_pkg::K_TICK;
  logic [7:0]  in_target_id = '0;
  logic [15:0] in_burst_time = '0;
  logic [7:0]  in_prio_level = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  out_status_code;
  logic [7:0]  out_assigned_id;
  logic        out_run_valid;
  logic [7:0]  out_run_id;
  logic [15:0] out_run_remaining;
  logic        out_retired_valid;
  logic        out_rotated_valid;
  logic [3:0]  out_ready_count;
  logic [3:0]  out_proc_count;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = prrs_pkg::CFG_MODE;
  logic [7:0]  cfg_wdata = '0;

  // Idle percentages for the sender and the receiver in the current phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;
  sched_scoreboard sb;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  priority_round_robin_scheduler u_top (.*);

  // Global watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: randomly stalls ready and checks every accepted response.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_response('{out_status_code, out_assigned_id, out_run_valid, out_run_id,
                          out_run_remaining, out_retired_valid, out_rotated_valid,
                          out_ready_count, out_proc_count});
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sends one request. Valid holds until the block accepts it; the prediction is
  // updated at that same edge so it sees the state in request order. The block
  // is busy in the cycle after an accept, so the wait before raising valid
  // again costs no throughput.
  task automatic send_request(logic [2:0] kind, logic [7:0] tgt, logic [15:0] burst,
                              logic [7:0] prio);
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1;
    in_kind <= kind;
    in_target_id <= tgt;
    in_burst_time <= burst;
    in_prio_level <= prio;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kind, tgt, burst, prio);
    in_valid <= 0;
  endtask

  // Waits for every pending response plus the worst-case request latency.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Random traffic: mostly adds and ticks so that processes dispatch, run out,
  // rotate and retire; ids are drawn mostly from the live range.
  task automatic random_traffic(int count);
    logic [2:0] kind;
    logic [7:0] tgt;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 25) kind = prrs_pkg::K_ADD;
      else if (r < 60) kind = prrs_pkg::K_TICK;
      else if (r < 99) kind = 3'($urandom_range(prrs_pkg::K_PREEMPT, prrs_pkg::K_RESUME));
      else kind = prrs_pkg::K_CLEAR;
      tgt = ($urandom_range(9) == 0) ? 8'($urandom) : 8'(sb.next_id - 1 - $urandom_range(7));
      send_request(kind, tgt,
                   ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(6)),
                   ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3)));
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part in priority mode: fill past the table limit, equal priorities,
    // extremes of the fields, preempt and block with nothing running, and
    // every command including bad ids and clear.
    send_request(prrs_pkg::K_TICK, 8'd0, 16'd0, 8'd0);
    send_request(prrs_pkg::K_PREEMPT, 8'd0, 16'd0, 8'd0);
    send_request(prrs_pkg::K_BLOCK, 8'd0, 16'd0, 8'd0);
    send_request(prrs_pkg::K_ADD, 8'hff, 16'hffff, 8'hff);
    send_request(prrs_pkg::K_ADD, 8'd0, 16'd0, 8'd0);
    send_request(prrs_pkg::K_ADD, 8'd0, 16'd2, 8'd7);
    send_request(prrs_pkg::K_ADD, 8'd0, 16'd1, 8'd7);
    send_request(prrs_pkg::K_ADD, 8'd0, 16'd3, 8'd0);
    send_request(prrs_pkg::K_ADD, 8'd0, 16'd4, 8'd9);
    send_request(prrs_pkg::K_ADD, 8'd0, 16'd5, 8'd1);
    send_request(prrs_pkg::K_TICK, 8'd0, 16'd0, 8'd0);
    send_request(prrs_pkg::K_TICK, 8'd0, 16'd0, 8'd0);
    send_request(prrs_pkg::K_TICK, 8'd0, 16'd0, 8'd0);
    send_request(prrs_pkg::K_BLOCK, 8'd0, 16'd0, 8'd0);
    send_request(prrs_pkg::K_WAKE, 8'd3, 16'd0, 8'd0);
    send_request(prrs_pkg::K_WAKE, 8'd4, 16'd0, 8'd0);
    send_request(prrs_pkg::K_SUSPEND, 8'd2, 16'd0, 8'd0);
    send_request(prrs_pkg::K_SUSPEND, 8'd2, 16'd0, 8'd0);
    send_request(prrs_pkg::K_RESUME, 8'd2, 16'd0, 8'd0);
    send_request(prrs_pkg::K_RESUME, 8'hff, 16'd0, 8'd0);
    send_request(prrs_pkg::K_TICK, 8'd0, 16'd0, 8'd0);
    send_request(prrs_pkg::K_PREEMPT, 8'd0, 16'd0, 8'd0);
    send_request(prrs_pkg::K_CLEAR, 8'd0, 16'd0, 8'd0);
    drain();

    // Phases step through modes, slice lengths (extremes included) and idling.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      write_cfg(prrs_pkg::CFG_MODE, {7'($urandom), ph[0]});
      case (ph)
        1: write_cfg(prrs_pkg::CFG_SLICE, 8'd1);
        3: write_cfg(prrs_pkg::CFG_SLICE, 8'd255);
        5: write_cfg(prrs_pkg::CFG_SLICE, 8'd0);
        default: write_cfg(prrs_pkg::CFG_SLICE, 8'($urandom_range(1, 6)));
      endcase
      random_traffic(250);
      drain();
    end

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/prrs_pkg.sv
rtl/prrs_cell.sv
rtl/priority_round_robin_scheduler.sv
bench/priority_round_robin_scheduler_tb.sv
